/* rtl/core/esfcp_pkg.sv */
`default_nettype none
package esfcp_pkg;

  // Default sizing of the core.
  localparam int unsigned RING_DEPTH_DEF     = 16;
  localparam int unsigned OVERFLOW_GRACE_DEF = 16;

  // Field widths.
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned SPEED_W  = 17;
  localparam int unsigned NUMER_W  = 24;
  localparam int unsigned INVCNT_W = 8;
  localparam int unsigned NFLAGS   = 3;

  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [SPEED_W-1:0]  speed_t;
  typedef logic [NUMER_W-1:0]  numer_t;
  typedef logic [INVCNT_W-1:0] invcnt_t;

  // Input word opcodes.
  typedef enum logic [1:0] {
    OP_CAPTURE  = 2'd0,
    OP_OVERFLOW = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MIN_PERIOD    = 2'd0,
    REG_MAX_AVERAGE   = 2'd1,
    REG_SPEED_NUMER   = 2'd2,
    REG_INVALID_LIMIT = 2'd3
  } reg_index_e;

  // Configuration reset values.
  localparam time_t   MIN_PERIOD_RST    = 16'd100;
  localparam time_t   MAX_AVERAGE_RST   = 16'd62330;
  localparam numer_t  SPEED_NUMER_RST   = 24'd8421000;
  localparam invcnt_t INVALID_LIMIT_RST = 8'd10;

  // Stored in the ring for a period that is too short.
  localparam time_t INVALID_MARK = 16'hFFFF;

  localparam speed_t SPEED_MAX = 17'h1FFFF;

  // Invalid counter reload once it climbs high.
  localparam invcnt_t INVCNT_CEIL   = 8'd250;
  localparam invcnt_t INVCNT_RELOAD = 8'd4;

  // Hysteresis thresholds, bit 0 is the lowest band.
  localparam speed_t FLAG_ON  [NFLAGS] = '{17'd500, 17'd1450, 17'd1750};
  localparam speed_t FLAG_OFF [NFLAGS] = '{17'd400, 17'd1350, 17'd1650};

  // Bit-serial divider: one quotient bit per cycle over the full numerator.
  localparam int unsigned DIV_STEPS = NUMER_W;

endpackage
`default_nettype wire

/* rtl/core/engine_speed_from_capture_periods_core.sv */
`default_nettype none
// Engine speed core for an input-capture tachometer. Each input word is a capture
// edge (opcode 0, with its timer value), a timer overflow tick (opcode 1) or a
// compute request (opcode 2); every word produces exactly one output word with the
// current speed and the three hysteresis flags, held in an output register so the
// next input word can be taken while a result waits. Capture, overflow and unused
// words go from the accepting cycle to ST_FINISH, which loads the output register
// once it is free. A compute word reads and sums the period ring through its single
// read port, runs the bit-serial divider to form the average, and when the ring is
// good, the average is in range and nonzero and the engine is not stale,
// runs the same divider again to divide the numerator by the average. The ring is
// a memory with one write and one read port; a valid bit per entry makes unwritten
// entries read as zero, so no clearing pass follows reset. Configuration writes are
// always accepted and should only be issued while the core is idle.
module engine_speed_from_capture_periods_core #(
  parameter int unsigned RING_DEPTH     = esfcp_pkg::RING_DEPTH_DEF,
  parameter int unsigned OVERFLOW_GRACE = esfcp_pkg::OVERFLOW_GRACE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [esfcp_pkg::NUMER_W-1:0] cfg_data_i,

  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic [esfcp_pkg::TIME_W-1:0]  capture_time_i,

  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [esfcp_pkg::SPEED_W-1:0] speed_o,
  output      logic                          above_500_o,
  output      logic                          above_1450_o,
  output      logic                          above_1750_o
);

  localparam int unsigned IDX_W   = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W   = esfcp_pkg::TIME_W + CNT_W;
  localparam int unsigned OVF_W   = $clog2(OVERFLOW_GRACE + 1);
  localparam int unsigned DCNT_W  = $clog2(esfcp_pkg::DIV_STEPS);
  localparam int unsigned TW      = esfcp_pkg::TIME_W;
  localparam int unsigned NW      = esfcp_pkg::NUMER_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_AVG_LOAD,
    ST_DIV_AVG,
    ST_CHECK,
    ST_DIV_SPD,
    ST_SAT,
    ST_FINISH
  } state_e;

  state_e state_q;

  // Configuration registers.
  esfcp_pkg::time_t   min_period_q;
  esfcp_pkg::time_t   max_average_q;
  esfcp_pkg::numer_t  speed_numer_q;
  esfcp_pkg::invcnt_t invalid_limit_q;

  // Measurement state.
  logic [TW-1:0]         ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld_q;
  logic [IDX_W-1:0]      wr_idx_q;
  esfcp_pkg::time_t      last_capture_q;
  logic [OVF_W-1:0]      ovf_cnt_q;
  logic                  stale_q;
  esfcp_pkg::invcnt_t    inv_cnt_q;
  esfcp_pkg::speed_t     speed_q;
  logic [esfcp_pkg::NFLAGS-1:0] flags_q;

  // Ring summation.
  logic [CNT_W-1:0] sum_cnt_q;
  logic [SUM_W-1:0] sum_q;
  logic             bad_q;
  logic [TW-1:0]    rd_data_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_addr;
  logic [TW-1:0]    entry;

  // Shared bit-serial restoring divider.
  logic [TW-1:0]     div_rem_q;
  logic [NW-1:0]     div_quo_q;
  logic [TW-1:0]     div_den_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic [TW:0]       div_shift;
  logic [TW:0]       div_sub;
  logic              div_ge;
  logic [TW-1:0]     div_rem_d;
  logic [NW-1:0]     div_quo_d;
  logic              div_last;

  // Output register.
  logic                         out_valid_q;
  esfcp_pkg::speed_t            out_speed_q;
  logic [esfcp_pkg::NFLAGS-1:0] out_flags_q;

  logic                         in_fire;
  logic                         cap_store;
  logic [TW-1:0]                period_raw;
  logic [TW-1:0]                period;
  logic [IDX_W-1:0]             wr_idx_next;
  logic [TW-1:0]                avg;
  esfcp_pkg::invcnt_t           inv_inc;
  logic [esfcp_pkg::NFLAGS-1:0] flags_d;
  logic                         out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // A capture is stored only with no intervening overflow and a later timestamp.
  assign cap_store   = (capture_time_i > last_capture_q) &&
                       (ovf_cnt_q == OVF_W'(OVERFLOW_GRACE));
  assign period_raw  = capture_time_i - last_capture_q;
  assign period      = (period_raw < min_period_q) ? esfcp_pkg::INVALID_MARK : period_raw;
  assign wr_idx_next = (wr_idx_q == '0) ? IDX_W'(RING_DEPTH - 1) : wr_idx_q - 1'b1;

  // The counter runs one past the last entry to drain the registered read.
  assign rd_addr = sum_cnt_q[IDX_W-1:0];
  assign entry   = rd_vld_q ? rd_data_q : '0;

  assign div_shift = {div_rem_q, div_quo_q[NW-1]};
  assign div_sub   = div_shift - {1'b0, div_den_q};
  assign div_ge    = (div_shift >= {1'b0, div_den_q});
  assign div_rem_d = div_ge ? div_sub[TW-1:0] : div_shift[TW-1:0];
  assign div_quo_d = {div_quo_q[NW-2:0], div_ge};
  assign div_last  = (div_cnt_q == DCNT_W'(esfcp_pkg::DIV_STEPS - 1));

  assign avg     = div_quo_q[TW-1:0];
  assign inv_inc = inv_cnt_q + 1'b1;

  // Flags follow the speed as it stands when the word completes.
  always_comb begin
    for (int i = 0; i < esfcp_pkg::NFLAGS; i++) begin
      flags_d[i] = flags_q[i];
      if (speed_q >= esfcp_pkg::FLAG_ON[i]) begin
        flags_d[i] = 1'b1;
      end
      if (speed_q < esfcp_pkg::FLAG_OFF[i]) begin
        flags_d[i] = 1'b0;
      end
    end
  end

  // Ring memory: written on a stored capture, read once a cycle.
  always_ff @(posedge clk_i) begin
    if (in_fire && (opcode_i == esfcp_pkg::OP_CAPTURE) && cap_store) begin
      ring_mem[wr_idx_q] <= period;
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      min_period_q    <= esfcp_pkg::MIN_PERIOD_RST;
      max_average_q   <= esfcp_pkg::MAX_AVERAGE_RST;
      speed_numer_q   <= esfcp_pkg::SPEED_NUMER_RST;
      invalid_limit_q <= esfcp_pkg::INVALID_LIMIT_RST;
      ring_vld_q      <= '0;
      wr_idx_q        <= IDX_W'(RING_DEPTH - 1);
      last_capture_q  <= '0;
      ovf_cnt_q       <= '0;
      stale_q         <= 1'b0;
      inv_cnt_q       <= '0;
      speed_q         <= '0;
      flags_q         <= '0;
      sum_cnt_q       <= '0;
      sum_q           <= '0;
      bad_q           <= 1'b0;
      rd_vld_q        <= 1'b0;
      div_rem_q       <= '0;
      div_quo_q       <= '0;
      div_den_q       <= '0;
      div_cnt_q       <= '0;
      out_valid_q     <= 1'b0;
      out_speed_q     <= '0;
      out_flags_q     <= '0;
    end else begin
      rd_vld_q <= ring_vld_q[rd_addr];

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          esfcp_pkg::REG_MIN_PERIOD:    min_period_q    <= cfg_data_i[TW-1:0];
          esfcp_pkg::REG_MAX_AVERAGE:   max_average_q   <= cfg_data_i[TW-1:0];
          esfcp_pkg::REG_SPEED_NUMER:   speed_numer_q   <= cfg_data_i;
          esfcp_pkg::REG_INVALID_LIMIT: invalid_limit_q <= cfg_data_i[esfcp_pkg::INVCNT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            unique case (opcode_i)
              esfcp_pkg::OP_CAPTURE: begin
                if (cap_store) begin
                  ring_vld_q[wr_idx_q] <= 1'b1;
                  wr_idx_q             <= wr_idx_next;
                end
                last_capture_q <= capture_time_i;
                ovf_cnt_q      <= OVF_W'(OVERFLOW_GRACE);
                stale_q        <= 1'b0;
                state_q        <= ST_FINISH;
              end
              esfcp_pkg::OP_OVERFLOW: begin
                if (ovf_cnt_q != '0) begin
                  ovf_cnt_q <= ovf_cnt_q - 1'b1;
                end else begin
                  stale_q <= 1'b1;
                end
                state_q <= ST_FINISH;
              end
              esfcp_pkg::OP_COMPUTE: begin
                sum_cnt_q <= '0;
                sum_q     <= '0;
                bad_q     <= 1'b0;
                state_q   <= ST_SUM;
              end
              default: begin
                state_q <= ST_FINISH;
              end
            endcase
          end
        end

        ST_SUM: begin
          // Entry read at the previous count arrives now.
          if (sum_cnt_q != '0) begin
            sum_q <= sum_q + SUM_W'(entry);
            if ((entry == '0) || (entry == esfcp_pkg::INVALID_MARK)) begin
              bad_q <= 1'b1;
            end
          end
          if (sum_cnt_q == CNT_W'(RING_DEPTH)) begin
            state_q <= ST_AVG_LOAD;
          end else begin
            sum_cnt_q <= sum_cnt_q + 1'b1;
          end
        end

        ST_AVG_LOAD: begin
          div_rem_q <= '0;
          div_quo_q <= NW'(sum_q);
          div_den_q <= TW'(RING_DEPTH);
          div_cnt_q <= '0;
          state_q   <= ST_DIV_AVG;
        end

        ST_DIV_AVG: begin
          div_rem_q <= div_rem_d;
          div_quo_q <= div_quo_d;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            state_q <= ST_CHECK;
          end
        end

        ST_CHECK: begin
          if ((avg > max_average_q) || stale_q) begin
            speed_q <= '0;
            state_q <= ST_FINISH;
          end else if (!bad_q) begin
            inv_cnt_q <= '0;
            if (avg == '0) begin
              speed_q <= '0;
              state_q <= ST_FINISH;
            end else begin
              div_rem_q <= '0;
              div_quo_q <= speed_numer_q;
              div_den_q <= avg;
              div_cnt_q <= '0;
              state_q   <= ST_DIV_SPD;
            end
          end else begin
            if (inv_inc >= invalid_limit_q) begin
              inv_cnt_q <= (inv_inc >= esfcp_pkg::INVCNT_CEIL) ?
                           esfcp_pkg::INVCNT_RELOAD : inv_inc;
              speed_q   <= '0;
            end else begin
              inv_cnt_q <= inv_inc;
            end
            state_q <= ST_FINISH;
          end
        end

        ST_DIV_SPD: begin
          div_rem_q <= div_rem_d;
          div_quo_q <= div_quo_d;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            state_q <= ST_SAT;
          end
        end

        ST_SAT: begin
          speed_q <= (div_quo_q > NW'(esfcp_pkg::SPEED_MAX)) ?
                     esfcp_pkg::SPEED_MAX : div_quo_q[esfcp_pkg::SPEED_W-1:0];
          state_q <= ST_FINISH;
        end

        ST_FINISH: begin
          // Wait here until the output register can take the new word.
          if (out_free) begin
            flags_q     <= flags_d;
            out_flags_q <= flags_d;
            out_speed_q <= speed_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign speed_o      = out_speed_q;
  assign above_500_o  = out_flags_q[0];
  assign above_1450_o = out_flags_q[1];
  assign above_1750_o = out_flags_q[2];

endmodule
`default_nettype wire

/* tb/sv/tb_engine_speed_from_capture_periods_core.sv */
`timescale 1ns / 100ps

module tb_engine_speed_from_capture_periods_core;

  // The core is built at its default sizing; the reading predictor below keeps
  // its own copy of that sizing.
  localparam int unsigned RING = 16;
  localparam int unsigned GRACE = 16;

  // A ring slot holding this value marks a period that was too short.
  localparam esfcp_pkg::time_t BAD_PERIOD = 16'hFFFF;
  // Largest speed that fits the output; larger quotients clamp to it.
  localparam int unsigned RPM_CAP = 131071;
  // The invalid-compute counter is reloaded once it climbs this high.
  localparam int unsigned STREAK_TOP = 250;
  localparam int unsigned STREAK_RELOAD = 4;

  // One output word as the core should present it. Bit 0 of bands is the
  // 500 rpm flag, bit 1 the 1450 rpm flag, bit 2 the 1750 rpm flag.
  typedef struct {
    esfcp_pkg::speed_t rpm;
    logic [2:0] bands;
  } reading_t;

  // Tachometer scoreboard: it carries its own copy of the core's state and
  // registers, works out the reading that each accepted input word must
  // produce, and compares the output words in order against those readings.
  class tach_scoreboard;
    esfcp_pkg::time_t   periods [RING];
    int unsigned        slot;
    esfcp_pkg::time_t   prev_stamp;
    int unsigned        grace;
    bit                 stale;
    esfcp_pkg::invcnt_t bad_streak;
    esfcp_pkg::speed_t  rpm;
    logic [2:0]         bands;

    esfcp_pkg::time_t   min_period;
    esfcp_pkg::time_t   max_average;
    esfcp_pkg::numer_t  numerator;
    esfcp_pkg::invcnt_t bad_limit;

    reading_t    readings_due [$];
    int unsigned mismatches;

    // Tallies for the closing summary.
    int unsigned op_seen [4];
    int unsigned good_computes, rejected, bad_computes, forced_zero, reloads, clamped;
    int unsigned band_moves;

    function new();
      foreach (periods[i]) periods[i] = '0;
      slot = RING - 1;
      prev_stamp = '0;
      grace = 0;
      stale = 1'b0;
      bad_streak = '0;
      rpm = '0;
      bands = '0;
      min_period = 16'd100;
      max_average = 16'd62330;
      numerator = 24'd8421000;
      bad_limit = 8'd10;
    endfunction

    // Register writes keep only the bits that the register holds.
    function void set_register(esfcp_pkg::reg_index_e idx, esfcp_pkg::numer_t value);
      case (idx)
        esfcp_pkg::REG_MIN_PERIOD:    min_period = value[15:0];
        esfcp_pkg::REG_MAX_AVERAGE:   max_average = value[15:0];
        esfcp_pkg::REG_SPEED_NUMER:   numerator = value;
        esfcp_pkg::REG_INVALID_LIMIT: bad_limit = value[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned waiting();
      return readings_due.size();
    endfunction

    function void capture(esfcp_pkg::time_t t);
      esfcp_pkg::time_t p;
      // A period is only stored when the timer did not wrap and no overflow
      // tick came in since the previous edge.
      if (t > prev_stamp && grace == GRACE) begin
        p = t - prev_stamp;
        if (p < min_period) p = BAD_PERIOD;
        periods[slot] = p;
        slot = (slot == 0) ? RING - 1 : slot - 1;
      end
      prev_stamp = t;
      grace = GRACE;
      stale = 1'b0;
    endfunction

    function void overflow();
      if (grace != 0) grace--;
      else stale = 1'b1;
    endfunction

    function void compute();
      int unsigned total;
      int unsigned avg;
      int unsigned q;
      bit          bad;
      total = 0;
      bad = 1'b0;
      foreach (periods[i]) begin
        if (periods[i] == BAD_PERIOD || periods[i] == 0) bad = 1'b1;
        total += periods[i];
      end
      avg = total / RING;
      if (avg > max_average || stale) begin
        // Too slow or no recent edges: speed drops, the counter is untouched.
        rpm = '0;
        rejected++;
        return;
      end
      if (!bad) begin
        q = (avg != 0) ? numerator / avg : 0;
        if (q > RPM_CAP) begin
          q = RPM_CAP;
          clamped++;
        end
        rpm = esfcp_pkg::speed_t'(q);
        bad_streak = '0;
        good_computes++;
      end else begin
        bad_computes++;
        bad_streak = bad_streak + 8'd1;
        if (bad_streak >= bad_limit) begin
          if (bad_streak >= STREAK_TOP) begin
            bad_streak = esfcp_pkg::invcnt_t'(STREAK_RELOAD);
            reloads++;
          end
          rpm = '0;
          forced_zero++;
        end
      end
    endfunction

    function void band(int b, int unsigned on_at, int unsigned off_below);
      logic was;
      was = bands[b];
      if (rpm >= on_at) bands[b] = 1'b1;
      if (rpm < off_below) bands[b] = 1'b0;
      if (bands[b] != was) band_moves++;
    endfunction

    // Called for every input word that the core accepts.
    function void note_word(esfcp_pkg::opcode_e op, esfcp_pkg::time_t t);
      op_seen[op]++;
      case (op)
        esfcp_pkg::OP_CAPTURE:  capture(t);
        esfcp_pkg::OP_OVERFLOW: overflow();
        esfcp_pkg::OP_COMPUTE:  compute();
        default: ;
      endcase
      band(0, 500, 400);
      band(1, 1450, 1350);
      band(2, 1750, 1650);
      readings_due.push_back('{rpm, bands});
    endfunction

    // Called for every output word that the core hands over.
    function void check_word(esfcp_pkg::speed_t rpm_o, logic a500, logic a1450,
                             logic a1750);
      reading_t want;
      if (readings_due.size() == 0) begin
        $error("output word with no reading due: speed %0d", rpm_o);
        mismatches++;
        return;
      end
      want = readings_due.pop_front();
      if (rpm_o !== want.rpm) begin
        $error("speed: expected %0d, got %0d", want.rpm, rpm_o);
        mismatches++;
      end
      if (a500 !== want.bands[0]) begin
        $error("above_500: expected %0b, got %0b", want.bands[0], a500);
        mismatches++;
      end
      if (a1450 !== want.bands[1]) begin
        $error("above_1450: expected %0b, got %0b", want.bands[1], a1450);
        mismatches++;
      end
      if (a1750 !== want.bands[2]) begin
        $error("above_1750: expected %0b, got %0b", want.bands[2], a1750);
        mismatches++;
      end
    endfunction
  endclass

  // Every input of the core holds a known value from time zero on.
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [1:0]        cfg_index_i = '0;
  esfcp_pkg::numer_t cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic [1:0]        opcode_i = '0;
  esfcp_pkg::time_t  capture_time_i = '0;
  logic              out_ready_i = 1'b0;

  logic              cfg_ready_o;
  logic              in_ready_o;
  logic              out_valid_o;
  esfcp_pkg::speed_t speed_o;
  logic              above_500_o;
  logic              above_1450_o;
  logic              above_1750_o;

  tach_scoreboard sb = new();

  // When set, neither side inserts any idle cycles, so runs of back-to-back
  // words reach the core as well.
  bit               steady = 1'b0;
  // Timer value of the last capture word sent; new captures advance from it.
  esfcp_pkg::time_t timer_now = '0;
  // Accepted words other than unused ones in the current phase, used to end each phase.
  int unsigned      phase_words;

  engine_speed_from_capture_periods_core #(
    .RING_DEPTH    (RING),
    .OVERFLOW_GRACE(GRACE)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .capture_time_i(capture_time_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .speed_o       (speed_o),
    .above_500_o   (above_500_o),
    .above_1450_o  (above_1450_o),
    .above_1750_o  (above_1750_o)
  );

  always #5 clk_i = ~clk_i;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Output words are sampled at the clock edge, before anything the edge
  // itself updates, and checked in order.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word(speed_o, above_500_o, above_1450_o, above_1750_o);
    end
  end

  // The receiving side stalls at random. Each pass starts right after an edge
  // and always ends on a later edge, so out_ready_i never gets two
  // assignments in one time step.
  initial begin : sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (steady ? 1 : $urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Offers one input word and returns at the edge where it is taken. Valid is
  // only dropped ahead of an idle gap, never in the step where it is raised
  // again for the next word.
  task automatic send_word(input esfcp_pkg::opcode_e op, input esfcp_pkg::time_t stamp);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    capture_time_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, stamp);
    if (op == esfcp_pkg::OP_CAPTURE) timer_now = stamp;
    if (op != esfcp_pkg::OP_UNUSED) phase_words++;
  endtask

  task automatic send_tick();
    send_word(esfcp_pkg::OP_OVERFLOW, esfcp_pkg::time_t'($urandom));
  endtask

  task automatic send_compute();
    send_word(esfcp_pkg::OP_COMPUTE, esfcp_pkg::time_t'($urandom));
  endtask

  // A capture one period after the previous one. When the timer wraps, an
  // overflow tick comes first about half the time, as it would on a target.
  task automatic capture_after(input int unsigned period);
    logic [16:0] next;
    next = 17'({1'b0, timer_now} + period);
    if (next[16] && $urandom_range(0, 1) == 1) send_tick();
    send_word(esfcp_pkg::OP_CAPTURE, next[15:0]);
  endtask

  // Lowers valid after the last word and waits until every reading is in.
  // Always called right after an accepted word, whose reading is still due, so it always waits on the clock.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input esfcp_pkg::reg_index_e idx, input esfcp_pkg::numer_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, value);
  endtask

  // Writes all four registers back to back while the core is idle. The data
  // bits above a narrow register are filled with noise; the core must drop them.
  task automatic configure(input esfcp_pkg::time_t lo_period,
                           input esfcp_pkg::time_t hi_average,
                           input esfcp_pkg::numer_t numer,
                           input esfcp_pkg::invcnt_t limit);
    write_reg(esfcp_pkg::REG_MIN_PERIOD, {8'($urandom), lo_period});
    write_reg(esfcp_pkg::REG_MAX_AVERAGE, {8'($urandom), hi_average});
    write_reg(esfcp_pkg::REG_SPEED_NUMER, numer);
    write_reg(esfcp_pkg::REG_INVALID_LIMIT, {16'($urandom), limit});
    cfg_valid_i <= 1'b0;
  endtask

  // Engine period for one run of edges. Most runs sit where the speed flags
  // switch with the default numerator; others are very fast, very slow or
  // anywhere at all.
  function automatic int unsigned pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(3500, 24000);
    if (r < 75) return $urandom_range(100, 3500);
    if (r < 85) return $urandom_range(24000, 65535);
    if (r < 95) return $urandom_range(1, 200);
    return $urandom_range(1, 65535);
  endfunction

  // A steady engine: captures a few percent around one period, computes
  // mixed in, and once in a while a stray overflow tick or unused word.
  task automatic engine_run();
    int unsigned n, base, p, r;
    n = $urandom_range(4, 24);
    base = pick_period();
    repeat (n) begin
      p = base + $urandom_range(0, base / 16) - base / 32;
      if (p < 1) p = 1;
      if (p > 65535) p = 65535;
      capture_after(p);
      r = $urandom_range(0, 99);
      if (r < 35) send_compute();
      else if (r < 39) send_tick();
      else if (r < 41) send_word(esfcp_pkg::OP_UNUSED, esfcp_pkg::time_t'($urandom));
    end
    send_compute();
  endtask

  // Edges that mostly come too fast, which put invalid marks into the ring.
  task automatic short_burst();
    repeat ($urandom_range(1, 4)) capture_after($urandom_range(1, 150));
    send_compute();
  endtask

  // The engine stops: overflow ticks pile up, often past the grace count.
  task automatic stall_run();
    repeat ($urandom_range(5, 24)) send_tick();
    send_compute();
    if ($urandom_range(0, 1) == 1) capture_after(pick_period());
  endtask

  // Any opcode with any timer value.
  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) begin
      send_word(esfcp_pkg::opcode_e'($urandom_range(0, 3)), esfcp_pkg::time_t'($urandom));
    end
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned r;
    phase_words = 0;
    while (phase_words < quota) begin
      steady = ($urandom_range(0, 99) < 12);
      r = $urandom_range(0, 99);
      if (r < 55) engine_run();
      else if (r < 68) short_burst();
      else if (r < 80) stall_run();
      else noise_burst();
    end
    steady = 1'b0;
  endtask

  // Refill the ring with moderate periods plus one invalid mark, then ask for
  // a long series of computes, so the invalid counter crosses its limit and
  // climbs until it is reloaded.
  task automatic invalid_streak();
    repeat (16) capture_after(1000);
    capture_after(1);
    repeat ($urandom_range(258, 264)) send_compute();
  endtask

  initial begin : main
    int unsigned ph;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the reset settings: compute on an empty ring, an
    // unused opcode, stale from the very first overflow tick, the first
    // capture after reset (never stored), a too-short period, a near-maximal
    // period, a timer wrap, a capture after an overflow tick, periods one
    // below and exactly at the minimum, and the extreme timer values.
    send_compute();
    send_word(esfcp_pkg::OP_UNUSED, 16'hFFFF);
    send_tick();
    send_compute();
    send_word(esfcp_pkg::OP_CAPTURE, 16'h0000);
    send_word(esfcp_pkg::OP_CAPTURE, 16'h0050);
    send_word(esfcp_pkg::OP_CAPTURE, 16'hFFFF);
    send_word(esfcp_pkg::OP_CAPTURE, 16'h0000);
    send_tick();
    send_word(esfcp_pkg::OP_CAPTURE, 16'd5000);
    send_word(esfcp_pkg::OP_CAPTURE, 16'd5099);
    send_word(esfcp_pkg::OP_CAPTURE, 16'd5199);
    send_word(esfcp_pkg::OP_UNUSED, 16'hAAAA);
    send_compute();
    send_word(esfcp_pkg::OP_CAPTURE, 16'h5555);
    send_word(esfcp_pkg::OP_CAPTURE, 16'hAAAA);
    send_compute();
    settle();

    // Register settings per phase: the reset values, both extremes, random
    // settings, and two phases for long runs of invalid computes.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: configure(16'd100, 16'd62330, 24'd8421000, 8'd10);
        1: configure(16'd0, 16'hFFFF, 24'hFFFFFF, 8'd1);
        2: configure(16'hFFFF, 16'd0, 24'd1, 8'd255);
        6: configure(16'd100, 16'd62330, 24'd8421000, 8'd255);
        7: configure(16'd100, 16'd62330, 24'd8421000, 8'($urandom_range(10, 120)));
        default: configure(16'($urandom_range(20, 400)), 16'($urandom_range(8000, 65535)),
                           24'($urandom_range(1000000, 16777215)),
                           8'($urandom_range(2, 40)));
      endcase
      if (ph >= 6) begin
        invalid_streak();
        random_phase(20);
      end else begin
        random_phase(25);
      end
      settle();
    end

    // A short quiet stretch catches any output word that was never asked for.
    repeat (100) @(posedge clk_i);
    if (sb.waiting() != 0) $error("%0d readings never arrived", sb.waiting());

    $display("Words: %0d captures, %0d overflow ticks, %0d computes, %0d unused.",
             sb.op_seen[esfcp_pkg::OP_CAPTURE], sb.op_seen[esfcp_pkg::OP_OVERFLOW],
             sb.op_seen[esfcp_pkg::OP_COMPUTE], sb.op_seen[esfcp_pkg::OP_UNUSED]);
    $display("Computes: %0d good, %0d rejected, %0d invalid, %0d forced to zero, %0d %s %0d",
             sb.good_computes, sb.rejected, sb.bad_computes, sb.forced_zero,
             sb.reloads, "counter reloads, clamped speeds:", sb.clamped);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin : watchdog
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule
